/* sv/nzc_pkg.sv */
// Shared types and constants for the near-plane triangle clipper.
`default_nettype none
package nzc_pkg;

  // Number of 32-bit coordinate words held per vertex: x y z w u v u2 v2.
  localparam int NWORDS = 8;

  // Coordinate word positions inside a vertex.
  localparam logic [2:0] W_X = 3'd0;
  localparam logic [2:0] W_Y = 3'd1;
  localparam logic [2:0] W_Z = 3'd2;
  localparam logic [2:0] W_W = 3'd3;
  localparam logic [2:0] W_U = 3'd4;
  localparam logic [2:0] W_V = 3'd5;
  localparam logic [2:0] W_U2 = 3'd6;
  localparam logic [2:0] W_V2 = 3'd7;

  // Interpolated channels: eight coordinate words, then four color bytes.
  localparam logic [3:0] CH_LAST = 4'd11;

  // Primitive assembly modes; the unused code behaves as separate triangles.
  localparam logic [1:0] MODE_TRI = 2'd0;
  localparam logic [1:0] MODE_STRIP = 2'd1;
  localparam logic [1:0] MODE_QUAD = 2'd2;

  // Configuration register indexes.
  localparam logic REG_NEAR_Z = 1'b0;
  localparam logic REG_PRIM_MODE = 1'b1;

  // Divider step counts: edge parameter (Q1.31) and reciprocal (2^32 / |w|).
  localparam logic [5:0] T_STEPS = 6'd31;
  localparam logic [5:0] R_STEPS = 6'd32;

  // Signed 32-bit saturation limits.
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [NWORDS-1:0][31:0] c;
    logic [31:0]             argb;
  } vtx_t;

  typedef enum logic [1:0] {
    MUL_INTERP,
    MUL_X,
    MUL_Y
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLAN,
    ST_ENTRY,
    ST_TDIV,
    ST_IMUL,
    ST_IACC,
    ST_RSTART,
    ST_RDIV,
    ST_MX,
    ST_MY,
    ST_MYW,
    ST_OUT,
    ST_NEXT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       slot_wr;
    logic [1:0] slot_idx;
    logic       shift;
    logic       tri_sel;
    logic [1:0] vk;
    logic [1:0] vj;
    logic       t_start;
    logic       r_start;
    logic       inv_load;
    logic       mul_en;
    mul_op_t    mul_op;
    logic [3:0] ch;
    logic       w_ch_load;
    logic       w_copy;
    logic       x_load;
    logic       y_load;
    logic       emit;
    logic       last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] outside;
    logic       div_done;
    logic       out_free;
    logic [1:0] prim_mode;
  } sts_t;

endpackage
`default_nettype wire

/* sv/nzc_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, remainder below divisor.
`default_nettype none
module nzc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [32:0] rem0,
  input  wire logic [32:0] den,
  input  wire logic [5:0]  steps,
  output logic [31:0]      quo,
  output logic             done
);
  import nzc_pkg::*;

  logic [32:0] rem_r, rem_nxt;
  logic [32:0] den_r;
  logic [31:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r;
  logic        done_r;
  logic [33:0] shifted;
  logic [33:0] diff;

  // One shift-and-subtract step.
  always_comb begin
    shifted = {rem_r, 1'b0};
    diff    = shifted - {1'b0, den_r};
    if (shifted >= {1'b0, den_r}) begin
      rem_nxt = diff[32:0];
      quo_nxt = {quo_r[30:0], 1'b1};
    end else begin
      rem_nxt = shifted[32:0];
      quo_nxt = {quo_r[30:0], 1'b0};
    end
  end

  // Step counter and done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= steps;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 6'd1);
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  // Remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem0;
      den_r <= den;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (cnt_r == '0)) else $error("divider restarted while busy");
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cnt_r == '0)) else $error("divider done with steps left");
`endif
endmodule
`default_nettype wire

/* sv/nzc_dp.sv */
// Clipper datapath: vertex slots, divider, shared multiplier and output register.
`default_nettype none
module nzc_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [31:0]   cfg_data,
  input  wire logic [31:0]   in_pos_x,
  input  wire logic [31:0]   in_pos_y,
  input  wire logic [31:0]   in_pos_z,
  input  wire logic [31:0]   in_pos_w,
  input  wire logic [31:0]   in_tex_u,
  input  wire logic [31:0]   in_tex_v,
  input  wire logic [31:0]   in_tex2_u,
  input  wire logic [31:0]   in_tex2_v,
  input  wire logic [31:0]   in_color_argb,
  input  wire nzc_pkg::cmd_t cmd,
  output nzc_pkg::sts_t      sts,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [31:0]        out_x,
  output logic [31:0]        out_y,
  output logic [31:0]        out_inv_w,
  output logic [31:0]        out_u,
  output logic [31:0]        out_v,
  output logic [31:0]        out_u2,
  output logic [31:0]        out_v2,
  output logic [31:0]        out_argb,
  output logic               out_end_of_list
);
  import nzc_pkg::*;

  logic signed [31:0] near_z_r;
  logic [1:0]         prim_mode_r;
  vtx_t               slot_r [4];
  vtx_t               in_vtx;
  vtx_t               tv [3];
  vtx_t               vo, vi;
  vtx_t               w_r;
  logic signed [32:0] zo, zi, nz, num, den;
  logic signed [31:0] ww;
  logic [32:0]        absw;
  logic [32:0]        div_rem0, div_den;
  logic [5:0]         div_steps;
  logic [31:0]        div_q;
  logic               div_done;
  logic signed [32:0] chan_o, chan_i, ma;
  logic signed [31:0] mb;
  logic signed [64:0] prod_r;
  logic signed [33:0] acc;
  logic [31:0]        inv_nxt, inv_r;
  logic signed [33:0] neg_q;
  logic [48:0]        scaled;
  logic [31:0]        scaled_sat;
  logic [31:0]        x_r, y_r;
  logic               out_valid_r;
  logic               out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_z_r    <= '0;
      prim_mode_r <= MODE_TRI;
    end else if (cfg_we) begin
      if (cfg_index == REG_NEAR_Z) begin
        near_z_r <= $signed(cfg_data);
      end else begin
        prim_mode_r <= cfg_data[1:0];
      end
    end
  end

  // Incoming vertex as a slot record.
  always_comb begin
    in_vtx.c[W_X]  = in_pos_x;
    in_vtx.c[W_Y]  = in_pos_y;
    in_vtx.c[W_Z]  = in_pos_z;
    in_vtx.c[W_W]  = in_pos_w;
    in_vtx.c[W_U]  = in_tex_u;
    in_vtx.c[W_V]  = in_tex_v;
    in_vtx.c[W_U2] = in_tex2_u;
    in_vtx.c[W_V2] = in_tex2_v;
    in_vtx.argb    = in_color_argb;
  end

  // Vertex slots; a strip drops its oldest vertex after each triangle.
  always_ff @(posedge clk) begin
    if (cmd.slot_wr) begin
      slot_r[cmd.slot_idx] <= in_vtx;
    end else if (cmd.shift) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  // Triangle corners: slots 0 1 2, or 0 2 3 for the second half of a quad.
  always_comb begin
    tv[0] = slot_r[0];
    tv[1] = cmd.tri_sel ? slot_r[2] : slot_r[1];
    tv[2] = cmd.tri_sel ? slot_r[3] : slot_r[2];
  end

  // Outer and inner endpoint of the current edge.
  always_comb begin
    unique case (cmd.vk)
      2'd1:    vo = tv[1];
      2'd2:    vo = tv[2];
      default: vo = tv[0];
    endcase
    unique case (cmd.vj)
      2'd1:    vi = tv[1];
      2'd2:    vi = tv[2];
      default: vi = tv[0];
    endcase
  end

  // Near plane test for each corner.
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      sts.outside[p] = $signed(tv[p].c[W_Z]) >= near_z_r;
    end
  end

  // Divider operands: edge parameter or reciprocal of |w|.
  always_comb begin
    zo   = 33'($signed(vo.c[W_Z]));
    zi   = 33'($signed(vi.c[W_Z]));
    nz   = 33'(near_z_r);
    num  = zo - nz;
    den  = zo - zi;
    ww   = $signed(w_r.c[W_W]);
    absw = ww[31] ? 33'(-33'(ww)) : 33'(ww);
    if (cmd.t_start) begin
      div_rem0  = num;
      div_den   = den;
      div_steps = T_STEPS;
    end else begin
      div_rem0  = 33'd1;
      div_den   = absw;
      div_steps = R_STEPS;
    end
  end

  nzc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.t_start | cmd.r_start),
    .rem0  (div_rem0),
    .den   (div_den),
    .steps (div_steps),
    .quo   (div_q),
    .done  (div_done)
  );

  // Channel endpoints: coordinate word or unsigned color byte.
  always_comb begin
    if (!cmd.ch[3]) begin
      chan_o = 33'($signed(vo.c[cmd.ch[2:0]]));
      chan_i = 33'($signed(vi.c[cmd.ch[2:0]]));
    end else begin
      chan_o = $signed({25'd0, vo.argb[{cmd.ch[1:0], 3'b000} +: 8]});
      chan_i = $signed({25'd0, vi.argb[{cmd.ch[1:0], 3'b000} +: 8]});
    end
  end

  // Shared multiplier operands.
  always_comb begin
    unique case (cmd.mul_op)
      MUL_X: begin
        ma = 33'($signed(w_r.c[W_X]));
        mb = $signed(inv_r);
      end
      MUL_Y: begin
        ma = 33'($signed(w_r.c[W_Y]));
        mb = $signed(inv_r);
      end
      default: begin
        ma = chan_i - chan_o;
        mb = $signed({1'b0, div_q[30:0]});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= ma * mb;
    end
  end

  // Interpolated channel: outer value plus floor of the scaled difference.
  assign acc = 34'(chan_o) + prod_r[64:31];

  // Working vertex.
  always_ff @(posedge clk) begin
    if (cmd.w_copy) begin
      w_r <= vo;
    end else if (cmd.w_ch_load) begin
      if (!cmd.ch[3]) begin
        w_r.c[cmd.ch[2:0]] <= acc[31:0];
      end else begin
        w_r.argb[{cmd.ch[1:0], 3'b000} +: 8] <= acc[7:0];
      end
    end
  end

  // Reciprocal with saturation; zero and unit magnitude are fixed up here.
  always_comb begin
    neg_q = -$signed({2'b00, div_q});
    if (ww == 32'sd0) begin
      inv_nxt = SAT_MAX;
    end else if (absw == 33'd1) begin
      inv_nxt = ww[31] ? SAT_MIN : SAT_MAX;
    end else if (ww[31]) begin
      inv_nxt = neg_q[31:0];
    end else begin
      inv_nxt = div_q[31] ? SAT_MAX : div_q;
    end
  end

  // Product scaled by 2^-16 and saturated.
  always_comb begin
    scaled = prod_r[64:16];
    if ((scaled[48:31] == '0) || (scaled[48:31] == '1)) begin
      scaled_sat = scaled[31:0];
    end else begin
      scaled_sat = scaled[48] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.inv_load) begin
      inv_r <= inv_nxt;
    end
    if (cmd.x_load) begin
      x_r <= scaled_sat;
    end
    if (cmd.y_load) begin
      y_r <= scaled_sat;
    end
  end

  // Output register.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x           <= x_r;
      out_y           <= y_r;
      out_inv_w       <= inv_r;
      out_u           <= w_r.c[W_U];
      out_v           <= w_r.c[W_V];
      out_u2          <= w_r.c[W_U2];
      out_v2          <= w_r.c[W_V2];
      out_argb        <= w_r.argb;
      out_end_of_list <= cmd.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.div_done  = div_done;
  assign sts.out_free  = out_free;
  assign sts.prim_mode = prim_mode_r;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free) else $error("item emitted over a held result");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r) else $error("result dropped");
`endif
endmodule
`default_nettype wire

/* sv/nzc_ctrl.sv */
// Clipper controller: primitive assembly, clip case selection and step sequencing.
`default_nettype none
module nzc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic          in_valid,
  input  wire logic          in_strip_end,
  output logic               in_stall,
  output nzc_pkg::cmd_t      cmd,
  input  wire nzc_pkg::sts_t sts
);
  import nzc_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] count_r, count_nxt;
  logic       tri_r, tri_nxt;
  logic       se_r, se_nxt;
  logic [1:0] ent_r, ent_nxt;
  logic [3:0] ch_r, ch_nxt;
  logic [1:0] mode;
  logic [2:0] ins;
  logic [1:0] n_in;
  logic [1:0] out_idx, in_idx, idx_a, idx_b;
  logic [1:0] vk, vj;
  logic       clip, last_ent;
  logic [1:0] slot;
  logic [2:0] cnt_inc;
  logic       need_tri;

  assign mode = (sts.prim_mode == 2'd3) ? MODE_TRI : sts.prim_mode;

  // Clip case of the current triangle.
  always_comb begin
    ins     = ~sts.outside;
    n_in    = 2'({1'b0, ins[0]} + {1'b0, ins[1]} + {1'b0, ins[2]});
    out_idx = sts.outside[2] ? 2'd2 : (sts.outside[1] ? 2'd1 : 2'd0);
    in_idx  = ins[2] ? 2'd2 : (ins[1] ? 2'd1 : 2'd0);
    idx_a   = (out_idx == 2'd2) ? 2'd0 : out_idx + 2'd1;
    idx_b   = (out_idx == 2'd0) ? 2'd2 : out_idx - 2'd1;
  end

  // Emitted vertex list: which corner, whether clipped and toward which corner.
  always_comb begin
    vk       = ent_r;
    vj       = in_idx;
    clip     = 1'b0;
    last_ent = (ent_r == 2'd2);
    if (n_in == 2'd2) begin
      last_ent = (ent_r == 2'd3);
      unique case (ent_r)
        2'd0: begin
          vk   = out_idx;
          vj   = idx_a;
          clip = 1'b1;
        end
        2'd1: vk = idx_a;
        2'd2: begin
          vk   = out_idx;
          vj   = idx_b;
          clip = 1'b1;
        end
        default: vk = idx_b;
      endcase
    end else if (n_in == 2'd1) begin
      unique case (ent_r)
        2'd1:    clip = sts.outside[1];
        2'd2:    clip = sts.outside[2];
        default: clip = sts.outside[0];
      endcase
    end
  end

  // Assembly count after the incoming vertex.
  always_comb begin
    slot     = count_r[1:0];
    cnt_inc  = {1'b0, slot} + 3'd1;
    need_tri = (mode == MODE_QUAD) ? (cnt_inc >= 3'd4) : (cnt_inc >= 3'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      tri_r   <= 1'b0;
      se_r    <= 1'b0;
      ent_r   <= '0;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      tri_r   <= tri_nxt;
      se_r    <= se_nxt;
      ent_r   <= ent_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    tri_nxt   = tri_r;
    se_nxt    = se_r;
    ent_nxt   = ent_r;
    ch_nxt    = ch_r;
    in_stall  = 1'b1;
    cmd           = '0;
    cmd.mul_op    = MUL_INTERP;
    cmd.slot_idx  = slot;
    cmd.tri_sel   = tri_r;
    cmd.vk        = vk;
    cmd.vj        = vj;
    cmd.ch        = ch_r;
    cmd.last      = last_ent;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (cfg_we && (cfg_index == REG_PRIM_MODE)) begin
          count_nxt = '0;
        end
        if (in_valid) begin
          cmd.slot_wr = 1'b1;
          if (need_tri) begin
            tri_nxt   = 1'b0;
            se_nxt    = in_strip_end;
            state_nxt = ST_PLAN;
          end else begin
            count_nxt = in_strip_end ? 3'd0 : cnt_inc;
          end
        end
      end
      ST_PLAN: begin
        ent_nxt   = '0;
        state_nxt = (n_in == 2'd0) ? ST_NEXT : ST_ENTRY;
      end
      ST_ENTRY: begin
        if (clip) begin
          cmd.t_start = 1'b1;
          state_nxt   = ST_TDIV;
        end else begin
          cmd.w_copy = 1'b1;
          state_nxt  = ST_RSTART;
        end
      end
      ST_TDIV: begin
        ch_nxt = '0;
        if (sts.div_done) begin
          state_nxt = ST_IMUL;
        end
      end
      ST_IMUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_IACC;
      end
      ST_IACC: begin
        cmd.w_ch_load = 1'b1;
        ch_nxt        = ch_r + 4'd1;
        state_nxt     = (ch_r == CH_LAST) ? ST_RSTART : ST_IMUL;
      end
      ST_RSTART: begin
        cmd.r_start = 1'b1;
        state_nxt   = ST_RDIV;
      end
      ST_RDIV: begin
        if (sts.div_done) begin
          cmd.inv_load = 1'b1;
          state_nxt    = ST_MX;
        end
      end
      ST_MX: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_X;
        state_nxt  = ST_MY;
      end
      ST_MY: begin
        cmd.x_load = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_Y;
        state_nxt  = ST_MYW;
      end
      ST_MYW: begin
        cmd.y_load = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          ent_nxt   = ent_r + 2'd1;
          state_nxt = last_ent ? ST_NEXT : ST_ENTRY;
        end
      end
      ST_NEXT: begin
        if ((mode == MODE_QUAD) && !tri_r) begin
          tri_nxt   = 1'b1;
          state_nxt = ST_PLAN;
        end else begin
          cmd.shift = (mode == MODE_STRIP);
          count_nxt = (se_r || (mode != MODE_STRIP)) ? 3'd0 : 3'd2;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_done_where_waited: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_TDIV || state_r == ST_RDIV))
    else $error("divider finished outside a wait state");
  a_entry_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ENTRY && n_in != 2'd2) |-> (ent_r != 2'd3))
    else $error("vertex list overrun");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd3) else $error("assembly count out of range");
`endif
endmodule
`default_nettype wire

/* sv/near_z_triangle_clipper_core.sv */
// Top level of the near-plane triangle clipper with perspective divide.
// A vertex that completes no primitive is taken without a stall; after a completing vertex
// the input stalls until every result of that item has been emitted to the output register.
// A clipped vertex runs the edge divide and a multiply and add per channel; every vertex
// then runs the reciprocal divide, x and y scaling and output, and waits on output stalls.
// Reset (synchronous, active low) clears the config, the state, the count and out_valid.
`default_nettype none
module near_z_triangle_clipper_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [31:0] in_pos_w,
  input  wire logic [31:0] in_tex_u,
  input  wire logic [31:0] in_tex_v,
  input  wire logic [31:0] in_tex2_u,
  input  wire logic [31:0] in_tex2_v,
  input  wire logic [31:0] in_color_argb,
  input  wire logic        in_strip_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic [31:0]      out_inv_w,
  output logic [31:0]      out_u,
  output logic [31:0]      out_v,
  output logic [31:0]      out_u2,
  output logic [31:0]      out_v2,
  output logic [31:0]      out_argb,
  output logic             out_end_of_list
);
  import nzc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nzc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .in_valid     (in_valid),
    .in_strip_end (in_strip_end),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  nzc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_pos_w        (in_pos_w),
    .in_tex_u        (in_tex_u),
    .in_tex_v        (in_tex_v),
    .in_tex2_u       (in_tex2_u),
    .in_tex2_v       (in_tex2_v),
    .in_color_argb   (in_color_argb),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_inv_w       (out_inv_w),
    .out_u           (out_u),
    .out_v           (out_v),
    .out_u2          (out_u2),
    .out_v2          (out_v2),
    .out_argb        (out_argb),
    .out_end_of_list (out_end_of_list)
  );

endmodule
`default_nettype wire

/* tb/tb_near_z_triangle_clipper_core.sv */
// Self-checking testbench for the near-plane triangle clipper core.
`timescale 1ns / 100ps
`default_nettype none
module tb_near_z_triangle_clipper_core;
  import nzc_pkg::*;

  // One clipper vertex as the predictor sees it: widened coordinates and color.
  typedef struct {
    longint c[8];
    logic [31:0] argb;
  } vert_t;

  // One expected output vertex.
  typedef struct {
    logic [31:0] x, y, inv_w, u, v, u2, v2, argb;
    logic eol;
  } outv_t;

  // Scoreboard: models the clipper and holds the expected output vertices.
  class clip_scoreboard;
    longint near_z;
    logic [1:0] mode;
    vert_t held[4];
    int count;
    outv_t pending[$];
    int errors;

    function new();
      near_z = 0;
      mode = MODE_TRI;
      count = 0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
      if (idx == REG_NEAR_Z) begin
        near_z = longint'($signed(val));
      end else begin
        mode = val[1:0];
        count = 0;
      end
    endfunction

    function longint floor_shr(longint p, int s);
      return p >>> s;
    endfunction

    function longint sat(longint val);
      if (val > 64'sd2147483647) return 64'sd2147483647;
      if (val < -64'sd2147483648) return -64'sd2147483648;
      return val;
    endfunction

    // Move an outside vertex along its edge toward the inside vertex.
    function vert_t edge_clip(vert_t o, vert_t i);
      vert_t r;
      longint num, den, t, a, b, ch;
      num = o.c[2] - near_z;
      den = o.c[2] - i.c[2];
      t = 0;
      if (num > 0 && den > 0) t = longint'((64'(num) << 31) / 64'(den));
      for (int k = 0; k < 8; k++) r.c[k] = o.c[k] + floor_shr((i.c[k] - o.c[k]) * t, 31);
      for (int k = 0; k < 32; k += 8) begin
        a = (o.argb >> k) & 8'hFF;
        b = (i.argb >> k) & 8'hFF;
        ch = a + floor_shr((b - a) * t, 31);
        r.argb[k +: 8] = ch[7:0];
      end
      return r;
    endfunction

    // Perspective divide and queue one output vertex.
    function void emit_vertex(vert_t vx, bit last);
      outv_t e;
      longint inv;
      if (vx.c[3] == 0) inv = 64'sd2147483647;
      else inv = sat(64'sd4294967296 / vx.c[3]);
      e.x = 32'(sat(floor_shr(vx.c[0] * inv, 16)));
      e.y = 32'(sat(floor_shr(vx.c[1] * inv, 16)));
      e.inv_w = 32'(inv);
      e.u = 32'(vx.c[4]);
      e.v = 32'(vx.c[5]);
      e.u2 = 32'(vx.c[6]);
      e.v2 = 32'(vx.c[7]);
      e.argb = vx.argb;
      e.eol = last;
      pending.push_back(e);
    endfunction

    function void clip_triangle(int s0, int s1, int s2);
      vert_t v[3];
      bit outs[3];
      int n_in, in_i, out_i, a, b;
      v[0] = held[s0];
      v[1] = held[s1];
      v[2] = held[s2];
      n_in = 0;
      in_i = 0;
      out_i = 0;
      for (int i = 0; i < 3; i++) begin
        outs[i] = v[i].c[2] >= near_z;
        if (outs[i]) out_i = i;
        else begin
          n_in++;
          in_i = i;
        end
      end
      if (n_in == 0) return;
      if (n_in == 3) begin
        for (int i = 0; i < 3; i++) emit_vertex(v[i], i == 2);
      end else if (n_in == 1) begin
        for (int i = 0; i < 3; i++)
          emit_vertex(outs[i] ? edge_clip(v[i], v[in_i]) : v[i], i == 2);
      end else begin
        a = (out_i + 1) % 3;
        b = (out_i + 2) % 3;
        emit_vertex(edge_clip(v[out_i], v[a]), 0);
        emit_vertex(v[a], 0);
        emit_vertex(edge_clip(v[out_i], v[b]), 0);
        emit_vertex(v[b], 1);
      end
    endfunction

    // Note an accepted input vertex.
    function void add_vertex(logic [31:0] w[8], logic [31:0] argb, logic se);
      int slot;
      logic [1:0] m;
      slot = count & 3;
      m = (mode == 2'd3) ? MODE_TRI : mode;
      for (int k = 0; k < 8; k++) held[slot].c[k] = longint'($signed(w[k]));
      held[slot].argb = argb;
      count = slot + 1;
      if (m == MODE_TRI) begin
        if (count >= 3) begin
          clip_triangle(0, 1, 2);
          count = 0;
        end
      end else if (m == MODE_STRIP) begin
        if (count >= 3) begin
          clip_triangle(0, 1, 2);
          held[0] = held[1];
          held[1] = held[2];
          count = 2;
        end
      end else if (count >= 4) begin
        clip_triangle(0, 1, 2);
        clip_triangle(0, 2, 3);
        count = 0;
      end
      if (se) count = 0;
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act);
      if (exp_v !== act) begin
        $error("%s expected %h actual %h", name, exp_v, act);
        errors++;
      end
    endfunction

    // Check one accepted output vertex against the oldest expectation.
    function void check_vertex(outv_t a);
      outv_t e;
      if (pending.size() == 0) begin
        $error("unexpected output vertex");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("out_x", e.x, a.x);
      cmp("out_y", e.y, a.y);
      cmp("out_inv_w", e.inv_w, a.inv_w);
      cmp("out_u", e.u, a.u);
      cmp("out_v", e.v, a.v);
      cmp("out_u2", e.u2, a.u2);
      cmp("out_v2", e.v2, a.v2);
      cmp("out_argb", e.argb, a.argb);
      cmp("out_end_of_list", 32'(e.eol), 32'(a.eol));
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0, cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0, in_strip_end = 0, out_stall = 0;
  logic in_stall, out_valid, out_end_of_list;
  logic [31:0] in_w[8];
  logic [31:0] in_color_argb = 0;
  logic [31:0] out_x, out_y, out_inv_w, out_u, out_v, out_u2, out_v2, out_argb;
  clip_scoreboard sb;
  bit long_hold = 0;
  int idle_cycles = 0;

  initial for (int k = 0; k < 8; k++) in_w[k] = 0;

  always #1 clk = ~clk;

  near_z_triangle_clipper_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_w[W_X]), .in_pos_y(in_w[W_Y]), .in_pos_z(in_w[W_Z]),
    .in_pos_w(in_w[W_W]), .in_tex_u(in_w[W_U]), .in_tex_v(in_w[W_V]),
    .in_tex2_u(in_w[W_U2]), .in_tex2_v(in_w[W_V2]),
    .in_color_argb(in_color_argb), .in_strip_end(in_strip_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_inv_w(out_inv_w), .out_u(out_u),
    .out_v(out_v), .out_u2(out_u2), .out_v2(out_v2), .out_argb(out_argb),
    .out_end_of_list(out_end_of_list)
  );

  // Monitor: check results and note inputs at the rising edge.
  always @(posedge clk) begin
    outv_t a;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        a.x = out_x; a.y = out_y; a.inv_w = out_inv_w; a.u = out_u;
        a.v = out_v; a.u2 = out_u2; a.v2 = out_v2; a.argb = out_argb;
        a.eol = out_end_of_list;
        sb.check_vertex(a);
      end
      if (in_valid && !in_stall) sb.add_vertex(in_w, in_color_argb, in_strip_end);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request.
  always @(negedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Offer one vertex and hold it until accepted.
  task automatic send_vertex(logic [31:0] w[8], logic [31:0] argb, logic se);
    in_valid <= 1'b1;
    for (int k = 0; k < 8; k++) in_w[k] <= w[k];
    in_color_argb <= argb;
    in_strip_end <= se;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random vertex: mostly moderate values near the plane, sometimes extremes.
  task automatic rand_vertex(output logic [31:0] w[8]);
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(0, 9) == 0) w[k] = $urandom();
      else w[k] = 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    end
    if ($urandom_range(0, 15) == 0) w[W_W] = 0;
  endtask

  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  initial begin
    logic [31:0] w[8];
    logic [1:0] modes[4] = '{MODE_TRI, MODE_STRIP, MODE_QUAD, 2'd3};
    logic [31:0] nears[4] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
    logic [31:0] zs[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                           32'h0002_0000, 32'h0, 32'hFFFE_0000};
    int sent, burst;
    sb = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme fields and the one- and two-inside clip cases in separate triangles.
    write_reg(REG_NEAR_Z, 32'h0);
    write_reg(REG_PRIM_MODE, MODE_TRI);
    for (int i = 0; i < 18; i++) begin
      for (int k = 0; k < 8; k++) w[k] = (i % 3 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      w[W_Z] = zs[i % 6];
      w[W_W] = (i == 4) ? 32'h0 : ((i % 2) ? 32'h0001_0000 : 32'h8000_0000);
      send_vertex(w, (i % 2) ? 32'hFFFF_FFFF : 32'h0, i == 16);
    end
    drain(400);

    // Random phases over each mode and plane depth.
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_PRIM_MODE, modes[ph % 4]);
      write_reg(REG_NEAR_Z, (ph < 4) ? nears[ph] : 32'($urandom_range(0, 32'h0004_0000)
                - 32'h0002_0000));
      for (int j = 0; j < 20; j++) begin
        if (ph == 2 && j == 2) fork
          begin
            long_hold = 1;
            repeat (3000) @(negedge clk);
            long_hold = 0;
          end
        join_none
        burst = $urandom_range(1, 6);
        rand_vertex(w);
        send_vertex(w, $urandom(), $urandom_range(0, 11) == 0);
        sent++;
        if (burst == 1) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 30)) @(negedge clk);
        end
      end
      drain(400);
    end

    drain(400);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
